// ===== rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants for the bit-granular copy engine.
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int unsigned StoreBytesDefault = 256;
   localparam int unsigned BitsPerByte       = 8;
   localparam int unsigned StoreAddrW        = 16;
   localparam int unsigned PosW              = 13;
   localparam int unsigned CountW            = 12;
   localparam int unsigned ChunkW            = 4;

   typedef enum logic [1:0] {
      ACT_WR_SRC = 2'd0,
      ACT_WR_DST = 2'd1,
      ACT_RD_DST = 2'd2,
      ACT_MOVE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MV_RD,
      ST_MV_WR
   } state_type;

   typedef enum logic {
      STAT_DONE  = 1'b0,
      STAT_RANGE = 1'b1
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  byte_address;
      logic [7:0]  byte_value;
      logic [10:0] src_bit_start;
      logic [10:0] dst_bit_start;
      logic [11:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic [StoreAddrW-1:0] wr_addr;
      logic [7:0]            wr_data;
      logic [StoreAddrW-1:0] rd_addr;
   } store_port_type;

endpackage

// ===== rtl/bgc_byte_store.sv =====
// ----------------------------------------------------------------------------
// bgc_byte_store
// Byte-wide store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bgc_byte_store #(
   parameter int unsigned DEPTH = bgc_pkg::StoreBytesDefault,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bgc_merge.sv =====
// ----------------------------------------------------------------------------
// bgc_merge
// Chunk shift and merge unit: sizes one byte-bounded chunk and splices the
// source bits into the destination byte.
// ----------------------------------------------------------------------------
module bgc_merge (
   input  logic [7:0]                  src_byte,
   input  logic [7:0]                  dst_byte,
   input  logic [2:0]                  src_off,
   input  logic [2:0]                  dst_off,
   input  logic [bgc_pkg::CountW-1:0]  remaining,
   output logic [bgc_pkg::ChunkW-1:0]  chunk_bits,
   output logic [7:0]                  merged
);

   logic [bgc_pkg::ChunkW-1:0] avail_src;
   logic [bgc_pkg::ChunkW-1:0] avail_dst;
   logic [bgc_pkg::ChunkW-1:0] avail;
   logic [7:0]                 src_top;
   logic [7:0]                 aligned;
   logic [7:0]                 head_mask;
   logic [7:0]                 mask;

   always_comb begin
      avail_src = 4'd8 - {1'b0, src_off};
      avail_dst = 4'd8 - {1'b0, dst_off};
      avail     = (avail_src < avail_dst) ? avail_src : avail_dst;
      if (remaining < bgc_pkg::CountW'(avail)) begin
         chunk_bits = remaining[bgc_pkg::ChunkW-1:0];
      end else begin
         chunk_bits = avail;
      end
      src_top   = src_byte << src_off;
      aligned   = src_top >> dst_off;
      head_mask = 8'hFF << (4'd8 - chunk_bits);
      mask      = head_mask >> dst_off;
      merged    = (dst_byte & ~mask) | (aligned & mask);
   end

endmodule

// ===== rtl/bgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgc_ctrl
// Sequencer: decodes actions, checks move ranges, walks a move chunk by
// chunk and holds the response register.
// ----------------------------------------------------------------------------
module bgc_ctrl #(
   parameter int unsigned STORE_BYTES = bgc_pkg::StoreBytesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bgc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bgc_pkg::rsp_type              rsp_data,
   output bgc_pkg::store_port_type       src_port,
   output bgc_pkg::store_port_type       dst_port,
   input  logic [7:0]                    dst_rd_data,
   output logic [2:0]                    src_off,
   output logic [2:0]                    dst_off,
   output logic [bgc_pkg::CountW-1:0]    remaining,
   input  logic [bgc_pkg::ChunkW-1:0]    chunk_bits,
   input  logic [7:0]                    merged
);

   localparam int unsigned LimitBits = STORE_BYTES * bgc_pkg::BitsPerByte;

   bgc_pkg::state_type            state_ff, state_in;
   logic [bgc_pkg::PosW-1:0]      src_pos_ff, src_pos_in;
   logic [bgc_pkg::PosW-1:0]      dst_pos_ff, dst_pos_in;
   logic [bgc_pkg::CountW-1:0]    rem_ff, rem_in;
   logic                          rd_zero_ff, rd_zero_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bgc_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          req_xfer;
   logic                          addr_ok;
   logic                          range_bad;
   logic [bgc_pkg::PosW-1:0]      src_end;
   logic [bgc_pkg::PosW-1:0]      dst_end;
   logic [bgc_pkg::PosW-1:0]      chunk_ext;

   assign req_ready = (state_ff == bgc_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign src_off   = src_pos_ff[2:0];
   assign dst_off   = dst_pos_ff[2:0];
   assign remaining = rem_ff;

   assign addr_ok   = 32'(req_data.byte_address) < 32'(STORE_BYTES);
   assign src_end   = bgc_pkg::PosW'(req_data.src_bit_start) +
                      bgc_pkg::PosW'(req_data.bit_count);
   assign dst_end   = bgc_pkg::PosW'(req_data.dst_bit_start) +
                      bgc_pkg::PosW'(req_data.bit_count);
   assign range_bad = (32'(src_end) > LimitBits) || (32'(dst_end) > LimitBits);
   assign chunk_ext = bgc_pkg::PosW'(chunk_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bgc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_pos_ff <= src_pos_in;
      dst_pos_ff <= dst_pos_in;
      rem_ff     <= rem_in;
      rd_zero_ff <= rd_zero_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      src_pos_in   = src_pos_ff;
      dst_pos_in   = dst_pos_ff;
      rem_in       = rem_ff;
      rd_zero_in   = rd_zero_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      src_port         = '0;
      dst_port         = '0;
      src_port.wr_addr = bgc_pkg::StoreAddrW'(req_data.byte_address);
      src_port.wr_data = req_data.byte_value;
      src_port.rd_addr = bgc_pkg::StoreAddrW'(src_pos_ff[bgc_pkg::PosW-1:3]);
      dst_port.wr_addr = bgc_pkg::StoreAddrW'(dst_pos_ff[bgc_pkg::PosW-1:3]);
      dst_port.wr_data = merged;
      dst_port.rd_addr = bgc_pkg::StoreAddrW'(dst_pos_ff[bgc_pkg::PosW-1:3]);

      case (state_ff)
         bgc_pkg::ST_IDLE: begin
            dst_port.rd_addr = bgc_pkg::StoreAddrW'(req_data.byte_address);
            if (req_xfer) begin
               rsp_in.read_data = 8'd0;
               rsp_in.status    = bgc_pkg::STAT_DONE;
               src_pos_in       = bgc_pkg::PosW'(req_data.src_bit_start);
               dst_pos_in       = bgc_pkg::PosW'(req_data.dst_bit_start);
               rem_in           = req_data.bit_count;
               rd_zero_in       = !addr_ok;
               case (req_data.action)
                  bgc_pkg::ACT_WR_SRC: begin
                     src_port.wr_en = addr_ok;
                     rsp_valid_in   = 1'b1;
                  end
                  bgc_pkg::ACT_WR_DST: begin
                     dst_port.wr_en   = addr_ok;
                     dst_port.wr_addr = bgc_pkg::StoreAddrW'(req_data.byte_address);
                     dst_port.wr_data = req_data.byte_value;
                     rsp_valid_in     = 1'b1;
                  end
                  bgc_pkg::ACT_RD_DST: begin
                     state_in = bgc_pkg::ST_READ;
                  end
                  default: begin
                     if (range_bad) begin
                        rsp_in.status = bgc_pkg::STAT_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_data.bit_count == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = bgc_pkg::ST_MV_RD;
                     end
                  end
               endcase
            end
         end
         bgc_pkg::ST_READ: begin
            rsp_in.read_data = rd_zero_ff ? 8'd0 : dst_rd_data;
            rsp_in.status    = bgc_pkg::STAT_DONE;
            rsp_valid_in     = 1'b1;
            state_in         = bgc_pkg::ST_IDLE;
         end
         bgc_pkg::ST_MV_RD: begin
            state_in = bgc_pkg::ST_MV_WR;
         end
         bgc_pkg::ST_MV_WR: begin
            dst_port.wr_en = 1'b1;
            src_pos_in     = src_pos_ff + chunk_ext;
            dst_pos_in     = dst_pos_ff + chunk_ext;
            rem_in         = rem_ff - bgc_pkg::CountW'(chunk_bits);
            if (rem_ff == bgc_pkg::CountW'(chunk_bits)) begin
               rsp_in.read_data = 8'd0;
               rsp_in.status    = bgc_pkg::STAT_DONE;
               rsp_valid_in     = 1'b1;
               state_in         = bgc_pkg::ST_IDLE;
            end else begin
               state_in = bgc_pkg::ST_MV_RD;
            end
         end
         default: begin
            state_in = bgc_pkg::ST_IDLE;
         end
      endcase
   end

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bgc_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while an item is in progress");

   a_chunk_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgc_pkg::ST_MV_WR) |->
         (chunk_bits != '0) && (bgc_pkg::CountW'(chunk_bits) <= rem_ff))
      else $error("chunk size out of range");

   a_move_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgc_pkg::ST_MV_WR) |->
         (32'(dst_pos_ff) < LimitBits) && (32'(src_pos_ff) < LimitBits))
      else $error("move position past end of store");

   a_chunk_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgc_pkg::ST_MV_WR) |=>
         (state_ff == bgc_pkg::ST_MV_RD) || (state_ff == bgc_pkg::ST_IDLE))
      else $error("bad step after chunk write");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgc_pkg::ST_READ) |=> rsp_valid_ff)
      else $error("read gave no response");

endmodule

// ===== rtl/bit_granular_copy.sv =====
// ----------------------------------------------------------------------------
// bit_granular_copy
// Bit-granular copy engine over a source and a destination byte store.
// ----------------------------------------------------------------------------
// Each request transfer on req_ writes a source byte, writes a destination
// byte, reads a destination byte, or runs a move of bit_count bits from a
// source bit offset to a destination bit offset (MSB-first within a byte).
// Each request yields exactly one response transfer on rsp_, in order,
// carrying read_data (read actions only) and status (range error on moves).
// Writes, empty moves and refused moves respond in the cycle after the request
// transfer; a read passes through the read state, which captures the registered
// destination store output. A move walks byte-bounded chunks through one
// shift/merge unit, each chunk a store read, then a read-modify-write of the
// destination byte; the number of chunks is about bit_count/8 to bit_count/4,
// depending on alignment. The next request can transfer at the edge that
// transfers the response, so one item holds the block until that response.
// req_ready is high only when the sequencer is idle and the response register
// is free or being drained. A stalled response holds its data and blocks the
// next request. Reset clears the sequencer and the response valid; the store
// contents are undefined until written.
// ----------------------------------------------------------------------------
module bit_granular_copy #(
   parameter int unsigned STORE_BYTES = bgc_pkg::StoreBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bgc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bgc_pkg::rsp_type rsp_data
);

   localparam int unsigned AddrW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   bgc_pkg::store_port_type       src_port;
   bgc_pkg::store_port_type       dst_port;
   logic [7:0]                    src_rd_data;
   logic [7:0]                    dst_rd_data;
   logic [2:0]                    src_off;
   logic [2:0]                    dst_off;
   logic [bgc_pkg::CountW-1:0]    remaining;
   logic [bgc_pkg::ChunkW-1:0]    chunk_bits;
   logic [7:0]                    merged;

   bgc_ctrl #(
      .STORE_BYTES(STORE_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .src_port    (src_port),
      .dst_port    (dst_port),
      .dst_rd_data (dst_rd_data),
      .src_off     (src_off),
      .dst_off     (dst_off),
      .remaining   (remaining),
      .chunk_bits  (chunk_bits),
      .merged      (merged)
   );

   bgc_byte_store #(
      .DEPTH(STORE_BYTES)
   ) u_src_store (
      .clock   (clock),
      .wr_en   (src_port.wr_en),
      .wr_addr (src_port.wr_addr[AddrW-1:0]),
      .wr_data (src_port.wr_data),
      .rd_addr (src_port.rd_addr[AddrW-1:0]),
      .rd_data (src_rd_data)
   );

   bgc_byte_store #(
      .DEPTH(STORE_BYTES)
   ) u_dst_store (
      .clock   (clock),
      .wr_en   (dst_port.wr_en),
      .wr_addr (dst_port.wr_addr[AddrW-1:0]),
      .wr_data (dst_port.wr_data),
      .rd_addr (dst_port.rd_addr[AddrW-1:0]),
      .rd_data (dst_rd_data)
   );

   bgc_merge u_merge (
      .src_byte   (src_rd_data),
      .dst_byte   (dst_rd_data),
      .src_off    (src_off),
      .dst_off    (dst_off),
      .remaining  (remaining),
      .chunk_bits (chunk_bits),
      .merged     (merged)
   );

endmodule
